@@ rtl/dtq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue: words, codes,
// controller states and the command/status groups between ctrl and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 48;
	localparam int HANDLE_BITS = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// action codes of a request word
	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	// outcome codes of a response word
	typedef enum logic [2:0] {
		OUT_ACCEPTED  = 3'd0,
		OUT_FULL      = 3'd1,
		OUT_FIRED     = 3'd2,
		OUT_CANCELLED = 3'd3,
		OUT_NONE      = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [1:0]             action;
		logic [TIME_BITS-1:0]   due_time;
		logic [HANDLE_BITS-1:0] timer_handle;
		logic [TIME_BITS-1:0]   current_time;
	} req_t;

	typedef struct packed {
		logic [2:0]             outcome;
		logic [HANDLE_BITS-1:0] fired_handle;
		logic [TIME_BITS-1:0]   fired_due;
		logic                   final_result;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_CANCEL,
		ST_TSCAN,
		ST_TPICK,
		ST_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic push;
		logic step;
		logic pick;
		logic flush;
	} dtq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic hold_valid;
		logic best_valid;
		logic cap_hit;
		logic scan_last;
		logic out_free;
	} dtq_sts_t;

endpackage

@@ rtl/dtq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_datapath
// Slot store, scan index, earliest-deadline tracker, held result and the
// response register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module dtq_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  dtq_pkg::req_t    req,
	input  dtq_pkg::dtq_cmd_t cmd,
	output dtq_pkg::dtq_sts_t sts,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dtq_pkg::rsp_t    rsp
);
	import dtq_pkg::*;

	// captured request
	logic [1:0]             op_q;
	logic [TIME_BITS-1:0]   due_q;
	logic [HANDLE_BITS-1:0] key_q;
	logic [TIME_BITS-1:0]   now_q;

	// slot store
	logic [TIME_BITS-1:0]   slot_due_q   [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] slot_owner_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] slot_valid_q;

	// scan and selection state
	logic [IDX_W-1:0]       idx_q;
	logic                   best_valid_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [TIME_BITS-1:0]   best_due_q;
	logic [HANDLE_BITS-1:0] best_owner_q;
	logic                   hold_valid_q;
	logic [TIME_BITS-1:0]   hold_due_q;
	logic [HANDLE_BITS-1:0] hold_owner_q;
	logic [CNT_W-1:0]       cnt_q;

	// response register
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [TIME_BITS-1:0]   rd_due;
	logic [HANDLE_BITS-1:0] rd_owner;
	logic                   rd_valid;
	logic                   scan_last;
	logic                   cap_hit;
	logic                   hit;
	logic                   t_elig;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic                   emit;
	rsp_t                   emit_rsp;
	logic [2:0]             hold_code;

	// read the slot under the scan index
	assign rd_due    = slot_due_q[idx_q];
	assign rd_owner  = slot_owner_q[idx_q];
	assign rd_valid  = slot_valid_q[idx_q];
	assign scan_last = (idx_q == IDX_W'(QUEUE_DEPTH - 1));
	assign cap_hit   = (cnt_q == CNT_W'(MAX_RESULTS));

	// cancel match and tick candidate at the scan index
	assign hit    = (op_q == ACT_CANCEL) && rd_valid && (rd_owner == key_q) && !cap_hit;
	assign t_elig = (op_q == ACT_TICK) && rd_valid && (rd_due <= now_q) &&
	                (!best_valid_q || (rd_due < best_due_q));

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign hold_code = (op_q == ACT_TICK) ? OUT_FIRED : OUT_CANCELLED;

	// word going to the response register
	always_comb begin
		emit     = 1'b0;
		emit_rsp = '0;
		if (cmd.push) begin
			emit             = 1'b1;
			emit_rsp.outcome = free_found ? OUT_ACCEPTED : OUT_FULL;
			emit_rsp.final_result = 1'b1;
		end else if ((cmd.step && hit && hold_valid_q) || (cmd.pick && hold_valid_q)) begin
			emit                  = 1'b1;
			emit_rsp.outcome      = hold_code;
			emit_rsp.fired_handle = hold_owner_q;
			emit_rsp.fired_due    = hold_due_q;
			emit_rsp.final_result = 1'b0;
		end else if (cmd.flush) begin
			emit                  = 1'b1;
			emit_rsp.final_result = 1'b1;
			if (hold_valid_q) begin
				emit_rsp.outcome      = hold_code;
				emit_rsp.fired_handle = hold_owner_q;
				emit_rsp.fired_due    = hold_due_q;
			end else begin
				emit_rsp.outcome = OUT_NONE;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			idx_q        <= '0;
			best_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
			cnt_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				best_valid_q <= 1'b0;
				hold_valid_q <= 1'b0;
				cnt_q        <= '0;
			end
			if (cmd.push && free_found)
				slot_valid_q[free_idx] <= 1'b1;
			if (cmd.step) begin
				idx_q <= scan_last ? '0 : idx_q + 1'b1;
				if (hit) begin
					slot_valid_q[idx_q] <= 1'b0;
					hold_valid_q        <= 1'b1;
					cnt_q               <= cnt_q + 1'b1;
				end
				if (t_elig)
					best_valid_q <= 1'b1;
			end
			if (cmd.pick) begin
				slot_valid_q[best_idx_q] <= 1'b0;
				hold_valid_q             <= 1'b1;
				cnt_q                    <= cnt_q + 1'b1;
				best_valid_q             <= 1'b0;
				idx_q                    <= '0;
			end
			if (cmd.flush)
				hold_valid_q <= 1'b0;
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.action;
			due_q <= req.due_time;
			key_q <= req.timer_handle;
			now_q <= req.current_time;
		end
		if (cmd.push && free_found) begin
			slot_due_q[free_idx]   <= due_q;
			slot_owner_q[free_idx] <= key_q;
		end
		if (cmd.step && t_elig) begin
			best_idx_q   <= idx_q;
			best_due_q   <= rd_due;
			best_owner_q <= rd_owner;
		end
		if (cmd.step && hit) begin
			hold_due_q   <= rd_due;
			hold_owner_q <= rd_owner;
		end
		if (cmd.pick) begin
			hold_due_q   <= best_due_q;
			hold_owner_q <= best_owner_q;
		end
		if (emit)
			rsp_q <= emit_rsp;
	end

	// status back to the controller
	always_comb begin
		sts.hit        = hit;
		sts.hold_valid = hold_valid_q;
		sts.best_valid = best_valid_q;
		sts.cap_hit    = cap_hit;
		sts.scan_last  = scan_last;
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a new word never overwrites one that is still stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!rsp_valid_q || !rsp_stall))
		else $error("response register overrun");

	// the picked slot is still pending
	a_pick_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> (best_valid_q && slot_valid_q[best_idx_q]))
		else $error("picked slot not pending");

	// a non-final word always leaves a newer entry held
	a_mid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_rsp.final_result) |=> hold_valid_q)
		else $error("non-final word without successor");

	// result count stays within the cap
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count over cap");

endmodule

@@ rtl/dtq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ctrl
// Controller state machine: takes a request, sequences push, cancel scan or
// repeated tick passes, and issues the closing word.
// ----------------------------------------------------------------------------
module dtq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_action,
	output logic              req_stall,
	input  dtq_pkg::dtq_sts_t sts,
	output dtq_pkg::dtq_cmd_t cmd
);
	import dtq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   cancel_wait;
	logic   pick_ok;
	logic   pick_wait;

	// cancel match must first push out the held word
	assign cancel_wait = sts.hit && sts.hold_valid && !sts.out_free;
	assign pick_ok     = sts.best_valid && !sts.cap_hit;
	assign pick_wait   = sts.hold_valid && !sts.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_action)
						ACT_PUSH:   state_d = ST_PUSH;
						ACT_CANCEL: state_d = ST_CANCEL;
						ACT_TICK:   state_d = ST_TSCAN;
						default:    state_d = ST_FLUSH;
					endcase
				end
			end
			ST_PUSH: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			ST_CANCEL: begin
				if (!cancel_wait && sts.scan_last)
					state_d = ST_FLUSH;
			end
			ST_TSCAN: begin
				if (sts.scan_last)
					state_d = ST_TPICK;
			end
			ST_TPICK: begin
				if (!pick_ok)
					state_d = ST_FLUSH;
				else if (!pick_wait)
					state_d = ST_TSCAN;
			end
			ST_FLUSH: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.load  = req_valid;
			ST_PUSH:   cmd.push  = sts.out_free;
			ST_CANCEL: cmd.step  = !cancel_wait;
			ST_TSCAN:  cmd.step  = 1'b1;
			ST_TPICK:  cmd.pick  = pick_ok && !pick_wait;
			ST_FLUSH:  cmd.flush = sts.out_free;
			default:   cmd       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// a request is taken only when no action is in progress
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q != ST_IDLE))
		else $error("request taken without starting an action");

endmodule

@@ rtl/deadline_timer_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Bounded store of pending timers with push, cancel-by-handle and tick
// (fire expired entries, earliest deadline first, ties to lower slot).
//
//   channel | handshake            | word
//   --------+----------------------+------------------------------------
//   req     | req_valid/req_stall  | action, due_time, timer_handle, now
//   rsp     | rsp_valid/rsp_stall  | outcome, handle, due, final flag
//
// Cancel makes one pass over the slots, a tick that fires k entries k + 1
// passes; each pass walks every slot through one shared compare unit.
// A code-3 action gives one none word.
// Reset clears the valid bits and all control; no clearing pass.
// A stalled rsp holds the scan where a word must leave; req stays stalled
// until the action's final word has entered the output register.
// ----------------------------------------------------------------------------
module deadline_timer_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dtq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dtq_pkg::rsp_t rsp
);
	import dtq_pkg::*;

	dtq_cmd_t cmd;
	dtq_sts_t sts;

	// sequencing
	dtq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.req_stall  (req_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// slot store and result path
	dtq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
